// File: hw/rtl/sbf_pkg.sv
// Shared constants and types for the sample batch framer.
package sbf_pkg;

  localparam int BYTE_W         = 8;
  localparam int SAMPLE_W       = 16;
  localparam int NUM_IN_SAMPLES = 4;
  localparam int CHANNELS_DEF   = 4;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [BYTE_W-1:0] HDR_BYTE      = 8'hBB;
  localparam logic [BYTE_W-1:0] TRL_BYTE      = 8'hCC;
  localparam logic [BYTE_W-1:0] CHR_ONE       = 8'h31;
  localparam logic [BYTE_W-1:0] CHR_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] LEN_RESET     = 8'd50;
  localparam logic [BYTE_W-1:0] LEN_MIN_CLOSE = 8'd2;

  // Position of the serializer within one measurement's bytes
  typedef enum logic [2:0] {
    ST_HDR,
    ST_CNT,
    ST_IND,
    ST_DATA,
    ST_TRL
  } pos_t;

  // Per-measurement instructions from the front end to the serializer
  typedef struct packed {
    logic              hdr;
    logic              trl;
    logic [BYTE_W-1:0] count;
    logic              indicator;
  } desc_ctrl_t;

endpackage

// File: hw/rtl/sbf_if.sv
// Valid/ready channel interfaces for measurements and frame bytes.
interface sbf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_ch0;
  logic [15:0] sample_ch1;
  logic [15:0] sample_ch2;
  logic [15:0] sample_ch3;
  logic        indicator;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, indicator,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, indicator,
    output ready
  );
endinterface

interface sbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (
    output valid, out_byte, run_last, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_byte, run_last, frame_end,
    output ready
  );
endinterface

// File: hw/rtl/sbf_front.sv
// Front end: length register, fill count and per-measurement classification.
module sbf_front #(
  parameter int CHANNELS = sbf_pkg::CHANNELS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  sbf_in_if.sink                                   in_if,
  input  logic                                     cfg_we,
  input  logic [sbf_pkg::BYTE_W-1:0]               cfg_data,
  input  logic                                     push_ready,
  output logic                                     push_valid,
  output sbf_pkg::desc_ctrl_t                      push_ctrl,
  output logic [CHANNELS-1:0][sbf_pkg::SAMPLE_W-1:0] push_samples
);

  logic [sbf_pkg::BYTE_W-1:0] len_r;
  logic [sbf_pkg::BYTE_W-1:0] fill_r;
  logic [sbf_pkg::BYTE_W-1:0] fill_nxt;
  logic [sbf_pkg::BYTE_W-1:0] fill_inc;
  logic [sbf_pkg::BYTE_W-1:0] eff_len;
  logic                       accept;
  logic                       enabled;
  logic                       close;

  // Take a measurement whenever the queue has room
  assign in_if.ready = push_ready;
  assign accept      = in_if.valid && push_ready;
  assign enabled     = (len_r != '0);

  // Classify: header on an empty frame, trailer once the frame is full
  assign fill_inc = fill_r + 8'd1;
  assign eff_len  = (len_r < sbf_pkg::LEN_MIN_CLOSE) ? sbf_pkg::LEN_MIN_CLOSE : len_r;
  assign close    = (fill_inc >= eff_len);

  always_comb begin
    fill_nxt = fill_r;
    if (accept && enabled) begin
      fill_nxt = close ? '0 : fill_inc;
    end
  end

  // Drop measurements while the length is zero
  assign push_valid          = in_if.valid && enabled;
  assign push_ctrl.hdr       = (fill_r == '0);
  assign push_ctrl.trl       = close;
  assign push_ctrl.count     = len_r;
  assign push_ctrl.indicator = in_if.indicator;

  // Map input fields onto channels; channels beyond the inputs send zero
  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    if (c == 0) begin : g_c0
      assign push_samples[c] = in_if.sample_ch0;
    end else if (c == 1) begin : g_c1
      assign push_samples[c] = in_if.sample_ch1;
    end else if (c == 2) begin : g_c2
      assign push_samples[c] = in_if.sample_ch2;
    end else if (c == 3) begin : g_c3
      assign push_samples[c] = in_if.sample_ch3;
    end else begin : g_cz
      assign push_samples[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= sbf_pkg::LEN_RESET;
      fill_r <= '0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_data;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

// File: hw/rtl/sbf_queue.sv
// Short FIFO that decouples the front end from the serializer.
module sbf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sbf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  // Store an entry on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/sbf_back.sv
// Serializer: walks one queued measurement out as frame bytes, one per cycle unless the output stalls.
module sbf_back #(
  parameter int CHANNELS = sbf_pkg::CHANNELS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       q_valid,
  output logic                                       q_pop,
  input  sbf_pkg::desc_ctrl_t                        q_ctrl,
  input  logic [CHANNELS-1:0][sbf_pkg::SAMPLE_W-1:0] q_samples,
  sbf_out_if.source                                  out_if
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  sbf_pkg::pos_t              pos_r;
  sbf_pkg::pos_t              pos_nxt;
  sbf_pkg::pos_t              cur;
  logic [CH_W-1:0]            ch_r;
  logic [CH_W-1:0]            ch_nxt;
  logic                       half_r;
  logic                       half_nxt;
  logic                       load;
  logic                       data_last;
  logic [sbf_pkg::SAMPLE_W-1:0] sel_sample;
  logic [sbf_pkg::BYTE_W-1:0] byte_val;
  logic                       last_val;
  logic                       fend_val;

  logic                       out_valid_r;
  logic [sbf_pkg::BYTE_W-1:0] out_byte_r;
  logic                       run_last_r;
  logic                       frame_end_r;

  // Load the output register when it is empty or being drained
  assign load       = q_valid && (!out_valid_r || out_if.ready);
  assign data_last  = (ch_r == CH_W'(CHANNELS - 1)) && half_r;
  assign sel_sample = q_samples[ch_r];

  // Skip header and count on measurements that continue a frame
  always_comb begin
    cur = pos_r;
    if (pos_r == sbf_pkg::ST_HDR && !q_ctrl.hdr) begin
      cur = sbf_pkg::ST_IND;
    end
  end

  // Select the byte and next position
  always_comb begin
    pos_nxt  = pos_r;
    ch_nxt   = ch_r;
    half_nxt = half_r;
    byte_val = '0;
    last_val = 1'b0;
    fend_val = 1'b0;
    case (cur)
      sbf_pkg::ST_HDR: begin
        byte_val = sbf_pkg::HDR_BYTE;
        pos_nxt  = sbf_pkg::ST_CNT;
      end
      sbf_pkg::ST_CNT: begin
        byte_val = q_ctrl.count;
        pos_nxt  = sbf_pkg::ST_IND;
      end
      sbf_pkg::ST_IND: begin
        byte_val = q_ctrl.indicator ? sbf_pkg::CHR_ONE : sbf_pkg::CHR_ZERO;
        pos_nxt  = sbf_pkg::ST_DATA;
        ch_nxt   = '0;
        half_nxt = 1'b0;
      end
      sbf_pkg::ST_DATA: begin
        byte_val = half_r ? sel_sample[7:0] : sel_sample[15:8];
        if (!half_r) begin
          half_nxt = 1'b1;
        end else if (!data_last) begin
          half_nxt = 1'b0;
          ch_nxt   = ch_r + 1'b1;
        end else if (q_ctrl.trl) begin
          pos_nxt = sbf_pkg::ST_TRL;
        end else begin
          last_val = 1'b1;
          pos_nxt  = sbf_pkg::ST_HDR;
        end
      end
      sbf_pkg::ST_TRL: begin
        byte_val = sbf_pkg::TRL_BYTE;
        last_val = 1'b1;
        fend_val = 1'b1;
        pos_nxt  = sbf_pkg::ST_HDR;
      end
      default: begin
        pos_nxt = sbf_pkg::ST_HDR;
      end
    endcase
    if (!load) begin
      pos_nxt  = pos_r;
      ch_nxt   = ch_r;
      half_nxt = half_r;
    end
  end

  // Release the queue entry with its final byte
  assign q_pop = load && last_val;

  // Hold position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= sbf_pkg::ST_HDR;
      ch_r   <= '0;
      half_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      ch_r   <= ch_nxt;
      half_r <= half_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= byte_val;
      run_last_r  <= last_val;
      frame_end_r <= fend_val;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_byte  = out_byte_r;
  assign out_if.run_last  = run_last_r;
  assign out_if.frame_end = frame_end_r;

endmodule

// File: hw/rtl/sample_batch_framer_unit.sv
// Sample batch framer: packs measurements into 0xBB/count/.../0xCC byte frames.
// Each measurement emits its indicator character and two bytes per channel
// (high byte first), preceded by header and count when it opens a frame and
// followed by the trailer when it closes one: 2*CHANNELS+1 to 2*CHANNELS+3
// bytes, 9 to 11 at four channels, because no measurement both opens and
// closes a frame. The serializer sends one byte per cycle unless the output
// stalls; the front end classifies and queues a measurement in the cycle it
// is accepted, and a two-entry queue lets new measurements enter while
// earlier ones still stream out. The first byte of a measurement passes
// through the queue and then the output register. A batch length of zero
// drops measurements; a length of one closes frames after two.
module sample_batch_framer_unit #(
  parameter int CHANNELS = sbf_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  sbf_in_if.sink                     in_if,
  sbf_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [sbf_pkg::BYTE_W-1:0] cfg_data
);

  localparam int SAMP_BITS = CHANNELS * sbf_pkg::SAMPLE_W;
  localparam int Q_W       = $bits(sbf_pkg::desc_ctrl_t) + SAMP_BITS;

  logic                                       push_valid;
  logic                                       push_ready;
  sbf_pkg::desc_ctrl_t                        push_ctrl;
  logic [CHANNELS-1:0][sbf_pkg::SAMPLE_W-1:0] push_samples;
  logic                                       q_valid;
  logic                                       q_pop;
  logic [Q_W-1:0]                             q_data;
  sbf_pkg::desc_ctrl_t                        q_ctrl;
  logic [CHANNELS-1:0][sbf_pkg::SAMPLE_W-1:0] q_samples;

  sbf_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .push_ready   (push_ready),
    .push_valid   (push_valid),
    .push_ctrl    (push_ctrl),
    .push_samples (push_samples)
  );

  sbf_queue #(
    .WIDTH (Q_W),
    .DEPTH (sbf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_ctrl, push_samples}),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_data)
  );

  // Split the queue word back into control and samples
  assign q_ctrl    = q_data[Q_W-1:SAMP_BITS];
  assign q_samples = q_data[SAMP_BITS-1:0];

  sbf_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_ctrl    (q_ctrl),
    .q_samples (q_samples),
    .out_if    (out_if)
  );

endmodule
